// ----- hdl/fr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fr_pkg: shared types and constants of the fraction reducer
// Holds the transfer payload structs and the magnitude widths used by the
// sequencer, the binary GCD unit and the restoring divider.
// ----------------------------------------------------------------------------
package fr_pkg;

	localparam int MAG_W = 32;
	localparam int CNT_W = $clog2(MAG_W);

	typedef logic [MAG_W-1:0] mag_t;

	typedef struct packed {
		logic signed [MAG_W-1:0] numerator;
		logic signed [MAG_W-1:0] denominator;
	} req_t;

	typedef struct packed {
		logic signed [MAG_W-1:0] reduced_numerator;
		logic signed [MAG_W-1:0] reduced_denominator;
		logic                    was_reduced;
		logic                    zero_denominator;
	} rsp_t;

	// Handshake between the sequencer and an iterative unit.
	typedef struct packed {
		logic start;
	} unit_cmd_t;

	typedef struct packed {
		logic done;
	} unit_sts_t;

endpackage
`default_nettype wire

// ----- hdl/fraction_reducer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_reducer: reduces a signed fraction to lowest terms
// A small sequencer drives a binary GCD unit and a restoring divider that is
// used once for each of the two magnitudes.
// ----------------------------------------------------------------------------
//
//   channel  | ports                      | payload
//   ---------+----------------------------+-------------------------------
//   request  | req_valid, req_ready, req  | numerator, denominator
//   response | rsp_valid, rsp_ready, rsp  | reduced values and two flags
//
// Zero numerators and unit magnitudes go straight to the output stage. Other
// items run the binary GCD loop, one shift or compare and subtract per cycle,
// and two divisions by the GCD follow when it is not one.
// req_ready is high only while the sequencer is idle; a finished result waits
// until the output register is free. Reset clears the sequencer, both units
// and the response valid flag.
// ----------------------------------------------------------------------------
module fraction_reducer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_ready,
	input  wire fr_pkg::req_t req,
	output logic              rsp_valid,
	input  wire logic         rsp_ready,
	output fr_pkg::rsp_t      rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_OUT
	} state_t;

	state_t            state_q;
	fr_pkg::mag_t      n_q;
	fr_pkg::mag_t      d_q;
	fr_pkg::mag_t      nmag_q;
	fr_pkg::mag_t      dmag_q;
	logic              nneg_q;
	logic              dneg_q;
	fr_pkg::mag_t      g_q;
	fr_pkg::mag_t      qn_q;
	fr_pkg::mag_t      dvd_q;
	fr_pkg::rsp_t      res_q;
	fr_pkg::rsp_t      rsp_q;
	logic              rsp_valid_q;
	fr_pkg::unit_cmd_t gcd_cmd_q;
	fr_pkg::unit_cmd_t div_cmd_q;

	fr_pkg::unit_sts_t gcd_sts;
	fr_pkg::unit_sts_t div_sts;
	fr_pkg::mag_t      gcd_val;
	fr_pkg::mag_t      quo_val;

	// Decode of the incoming item: a zero denominator is taken as one, and
	// both values are split into sign and magnitude. The most negative value
	// simply yields a magnitude of two to the 31st.
	logic         den_zero;
	fr_pkg::mag_t d_fix;
	logic         nneg;
	logic         dneg;
	fr_pkg::mag_t nmag;
	fr_pkg::mag_t dmag;

	always_comb begin
		den_zero = req.denominator == '0;
		d_fix    = den_zero ? fr_pkg::mag_t'(1) : fr_pkg::mag_t'(req.denominator);
		nneg     = req.numerator[fr_pkg::MAG_W-1];
		dneg     = d_fix[fr_pkg::MAG_W-1];
		nmag     = nneg ? (fr_pkg::mag_t'(0) - fr_pkg::mag_t'(req.numerator))
		                : fr_pkg::mag_t'(req.numerator);
		dmag     = dneg ? (fr_pkg::mag_t'(0) - d_fix) : d_fix;
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	fr_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (gcd_cmd_q),
		.a_in   (nmag_q),
		.b_in   (dmag_q),
		.sts    (gcd_sts),
		.gcd    (gcd_val)
	);

	fr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd_q),
		.dividend (dvd_q),
		.divisor  (g_q),
		.sts      (div_sts),
		.quotient (quo_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			d_q         <= '0;
			nmag_q      <= '0;
			dmag_q      <= '0;
			nneg_q      <= 1'b0;
			dneg_q      <= 1'b0;
			g_q         <= '0;
			qn_q        <= '0;
			dvd_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			gcd_cmd_q   <= '0;
			div_cmd_q   <= '0;
		end else begin
			gcd_cmd_q.start <= 1'b0;
			div_cmd_q.start <= 1'b0;
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						n_q    <= fr_pkg::mag_t'(req.numerator);
						d_q    <= d_fix;
						nmag_q <= nmag;
						dmag_q <= dmag;
						nneg_q <= nneg;
						dneg_q <= dneg;
						res_q.zero_denominator <= den_zero;
						if (nmag == '0) begin
							// Zero over the sign of the denominator, always a change.
							res_q.reduced_numerator   <= '0;
							res_q.reduced_denominator <= dneg ? '1 : fr_pkg::MAG_W'(1);
							res_q.was_reduced         <= 1'b1;
							state_q                   <= S_OUT;
						end else if (nmag == fr_pkg::mag_t'(1) || dmag == fr_pkg::mag_t'(1)) begin
							res_q.reduced_numerator   <= req.numerator;
							res_q.reduced_denominator <= d_fix;
							res_q.was_reduced         <= 1'b0;
							state_q                   <= S_OUT;
						end else begin
							gcd_cmd_q.start <= 1'b1;
							state_q         <= S_GCD;
						end
					end
				end
				S_GCD: begin
					if (gcd_sts.done) begin
						if (gcd_val == fr_pkg::mag_t'(1)) begin
							// Already in lowest terms.
							res_q.reduced_numerator   <= n_q;
							res_q.reduced_denominator <= d_q;
							res_q.was_reduced         <= 1'b0;
							state_q                   <= S_OUT;
						end else begin
							g_q             <= gcd_val;
							dvd_q           <= nmag_q;
							div_cmd_q.start <= 1'b1;
							state_q         <= S_DIVN;
						end
					end
				end
				S_DIVN: begin
					if (div_sts.done) begin
						qn_q            <= quo_val;
						dvd_q           <= dmag_q;
						div_cmd_q.start <= 1'b1;
						state_q         <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (div_sts.done) begin
						res_q.reduced_numerator <= nneg_q ? (fr_pkg::mag_t'(0) - qn_q) : qn_q;
						res_q.reduced_denominator <= dneg_q ? (fr_pkg::mag_t'(0) - quo_val)
						                                    : quo_val;
						res_q.was_reduced       <= 1'b1;
						state_q                 <= S_OUT;
					end
				end
				S_OUT: begin
					// Load the output register once the previous result has gone.
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// The GCD unit reports only while the sequencer waits for it.
	a_gcd_done_in_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_sts.done |-> state_q == S_GCD)
		else $error("GCD unit finished outside the GCD state");

	// The divider reports only during one of the two divisions.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == S_DIVN || state_q == S_DIVD))
		else $error("divider finished outside a division state");

	// A transfer in always leaves the idle state.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after a request transfer");

	// A replaced zero denominator always comes out as plus one.
	a_zero_den_is_one: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.zero_denominator) |-> rsp.reduced_denominator == 32'sd1)
		else $error("zero denominator did not give a denominator of one");
`endif

endmodule
`default_nettype wire

// ----- hdl/fr_gcd.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fr_gcd: iterative binary GCD unit
// One shift, or one compare and subtract, per cycle on two nonzero magnitudes.
// ----------------------------------------------------------------------------
module fr_gcd (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fr_pkg::unit_cmd_t cmd,
	input  wire fr_pkg::mag_t      a_in,
	input  wire fr_pkg::mag_t      b_in,
	output fr_pkg::unit_sts_t      sts,
	output fr_pkg::mag_t          gcd
);

	typedef enum logic [1:0] {
		G_IDLE,
		G_TWOS,
		G_AODD,
		G_LOOP
	} phase_t;

	phase_t                    phase_q;
	fr_pkg::mag_t              a_q;
	fr_pkg::mag_t              b_q;
	logic [fr_pkg::CNT_W-1:0] shift_q;
	logic                      done_q;
	fr_pkg::mag_t              gcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= G_IDLE;
			a_q     <= '0;
			b_q     <= '0;
			shift_q <= '0;
			done_q  <= 1'b0;
			gcd_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				G_IDLE: begin
					if (cmd.start) begin
						a_q     <= a_in;
						b_q     <= b_in;
						shift_q <= '0;
						phase_q <= G_TWOS;
					end
				end
				G_TWOS: begin
					// Strip the common factors of two and count them.
					if (!a_q[0] && !b_q[0]) begin
						a_q     <= a_q >> 1;
						b_q     <= b_q >> 1;
						shift_q <= shift_q + fr_pkg::CNT_W'(1);
					end else begin
						phase_q <= G_AODD;
					end
				end
				G_AODD: begin
					if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else begin
						phase_q <= G_LOOP;
					end
				end
				G_LOOP: begin
					if (b_q == '0) begin
						gcd_q   <= a_q << shift_q;
						done_q  <= 1'b1;
						phase_q <= G_IDLE;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_q > b_q) begin
						a_q <= b_q;
						b_q <= a_q - b_q;
					end else begin
						b_q <= b_q - a_q;
					end
				end
				default: phase_q <= G_IDLE;
			endcase
		end
	end

	assign sts.done = done_q;
	assign gcd      = gcd_q;

endmodule
`default_nettype wire

// ----- hdl/fr_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fr_div: restoring divider
// Produces one quotient bit per cycle; used twice by the sequencer for each item whose GCD is not one.
// ----------------------------------------------------------------------------
module fr_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fr_pkg::unit_cmd_t cmd,
	input  wire fr_pkg::mag_t      dividend,
	input  wire fr_pkg::mag_t      divisor,
	output fr_pkg::unit_sts_t      sts,
	output fr_pkg::mag_t          quotient
);

	logic                      busy_q;
	logic                      done_q;
	logic [fr_pkg::CNT_W-1:0] cnt_q;
	fr_pkg::mag_t              rem_q;
	fr_pkg::mag_t              quo_q;
	fr_pkg::mag_t              dsr_q;

	logic [fr_pkg::MAG_W:0] trial;
	logic [fr_pkg::MAG_W:0] diff;
	logic                   fits;

	always_comb begin
		trial = {rem_q, quo_q[fr_pkg::MAG_W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (cmd.start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
					rem_q  <= '0;
					quo_q  <= dividend;
					dsr_q  <= divisor;
				end
			end else begin
				// The dividend shifts out of the top while quotient bits enter below.
				rem_q <= fits ? diff[fr_pkg::MAG_W-1:0] : trial[fr_pkg::MAG_W-1:0];
				quo_q <= {quo_q[fr_pkg::MAG_W-2:0], fits};
				cnt_q <= cnt_q + fr_pkg::CNT_W'(1);
				if (cnt_q == fr_pkg::CNT_W'(fr_pkg::MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the fraction reducer
// A queue of pending fractions feeds a clocked driver on the request channel,
// and a clocked monitor checks every response against a local predictor. The
// predictor reduces each fraction by a binary GCD. The run passes through
// phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top;

	// Drain time at the end of the run, meant to be comfortably more than
	// the longest item needs inside the block.
	localparam int DRAIN_CYCLES = 250;
	localparam int RANDOM_PER_PHASE = 300;
	localparam int NUM_DIRECTED = 24;
	localparam int MAX_MAG = 2147483647;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	fr_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	fr_pkg::rsp_t rsp;

	// Transfers seen at the last rising edge, read by the driver at the
	// falling edge that follows.
	logic req_fire = 1'b0;

	// Idling of each side, as a percentage of cycles.
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;

	fr_pkg::req_t pending_fractions[$];
	fr_pkg::rsp_t expected_reductions[$];
	int unsigned mismatch_count = 0;

	// Hand-picked fractions: zero denominators, zero numerators, unit
	// magnitudes, the extremes of the range and a few with shared factors.
	int directed_num [NUM_DIRECTED] = '{
		0, 5, -5, 0, 0, 0, 0, 1, -1, 9, 9, 2147483647,
		-2147483647, 2147483647, 6, -6, 6, -6, 12, 1073741824, 7, 1024,
		2147483646, -2147483647
	};
	int directed_den [NUM_DIRECTED] = '{
		0, 0, 0, 7, -7, 1, -1, 1, 9, 1, -1, 2147483647,
		2147483647, -2147483647, 4, 4, -4, -4, 18, 1048576, 13, -512,
		1073741823, 0
	};

	fraction_reducer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the response that the block owes for one request. The
	// magnitudes are taken as unsigned 32-bit values, so the most negative
	// pattern would simply become a magnitude of two to the thirty-first.
	function automatic fr_pkg::rsp_t reduce_fraction(input fr_pkg::req_t item);
		fr_pkg::rsp_t res;
		logic [31:0] num;
		logic [31:0] den;
		logic [31:0] nmag;
		logic [31:0] dmag;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] swap;
		logic [31:0] divisor;
		logic nneg;
		logic dneg;
		int shift;
		num = item.numerator;
		den = item.denominator;
		res.zero_denominator = (den == 32'd0);
		res.was_reduced = 1'b0;
		if (den == 32'd0) begin
			den = 32'd1;
		end
		nneg = num[31];
		dneg = den[31];
		nmag = nneg ? -num : num;
		dmag = dneg ? -den : den;
		if (nmag == 32'd0) begin
			// Zero over anything collapses to zero over the sign, and
			// always counts as a change.
			den = dneg ? 32'hffff_ffff : 32'd1;
			res.was_reduced = 1'b1;
		end else if (nmag != 32'd1 && dmag != 32'd1) begin
			x = nmag;
			y = dmag;
			shift = 0;
			while (((x | y) & 32'd1) == 32'd0) begin
				x = x >> 1;
				y = y >> 1;
				shift++;
			end
			while (!x[0]) begin
				x = x >> 1;
			end
			while (y != 32'd0) begin
				while (!y[0]) begin
					y = y >> 1;
				end
				if (x > y) begin
					swap = x;
					x = y;
					y = swap;
				end
				y = y - x;
			end
			divisor = x << shift;
			if (divisor > 32'd1) begin
				num = nneg ? -(nmag / divisor) : nmag / divisor;
				den = dneg ? -(dmag / divisor) : dmag / divisor;
				res.was_reduced = 1'b1;
			end
		end
		res.reduced_numerator = num;
		res.reduced_denominator = den;
		return res;
	endfunction

	function automatic logic [31:0] signed_field(input longint unsigned mag, input bit neg);
		logic [31:0] value;
		value = mag[31:0];
		return neg ? -value : value;
	endfunction

	// One fair random bit.
	function automatic bit coin();
		return 1'($urandom_range(1, 0));
	endfunction

	// Draws one random request. Nearly half of the draws share a common factor so
	// that the GCD loop and both divisions see real work; the rest are raw 32-bit
	// patterns, small values, powers of two times small odd factors, zeros and unit values.
	function automatic fr_pkg::req_t random_fraction();
		fr_pkg::req_t item;
		int unsigned kind;
		int unsigned bits;
		longint unsigned factor;
		longint unsigned bound;
		longint unsigned mag;
		kind = $urandom_range(99, 0);
		if (kind < 45) begin
			bits = $urandom_range(30, 1);
			factor = longint'($urandom) % (longint'(1) << bits);
			if (factor < 2) begin
				factor = 2;
			end
			bound = MAX_MAG / factor;
			item.numerator = signed_field($urandom_range(32'(bound), 1) * factor, coin());
			item.denominator = signed_field($urandom_range(32'(bound), 1) * factor, coin());
		end else if (kind < 70) begin
			// Raw patterns reach every bit; the one pattern outside the
			// range is drawn again.
			do begin
				item.numerator = $urandom;
			end while (item.numerator == 32'h8000_0000);
			do begin
				item.denominator = $urandom;
			end while (item.denominator == 32'h8000_0000);
		end else if (kind < 82) begin
			item.numerator = $signed($urandom_range(40, 0)) - 20;
			item.denominator = $signed($urandom_range(40, 0)) - 20;
		end else if (kind < 90) begin
			mag = (longint'(1) << $urandom_range(30, 0)) * (2 * $urandom_range(3, 0) + 1);
			if (mag > MAX_MAG) begin
				mag = longint'(1) << 30;
			end
			item.numerator = signed_field(mag, coin());
			mag = (longint'(1) << $urandom_range(30, 0)) * (2 * $urandom_range(3, 0) + 1);
			if (mag > MAX_MAG) begin
				mag = longint'(1) << 29;
			end
			item.denominator = signed_field(mag, coin());
		end else if (kind < 95) begin
			item.numerator = signed_field($urandom_range(MAX_MAG, 0), coin());
			item.denominator = signed_field($urandom_range(MAX_MAG, 0), coin());
			if (coin()) begin
				item.numerator = '0;
			end else begin
				item.denominator = '0;
			end
		end else begin
			item.numerator = signed_field($urandom_range(MAX_MAG, 1), coin());
			item.denominator = signed_field($urandom_range(MAX_MAG, 1), coin());
			if (coin()) begin
				item.numerator = signed_field(1, coin());
			end else begin
				item.denominator = signed_field(1, coin());
			end
		end
		return item;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Driver. Inputs move only at the falling edge. A request stays on the
	// bus until the edge that transfers it; only then does the driver load
	// the next one or drop valid, so valid is never lowered while an item
	// waits. The receiver's ready is redrawn every cycle.
	always @(negedge clk) begin
		if (arst_n) begin
			rsp_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
			if (!req_valid || req_fire) begin
				if (pending_fractions.size() != 0 &&
						$urandom_range(99, 0) >= sender_idle_pct) begin
					req <= pending_fractions.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Both channels are sampled at the rising edge, before the
	// block's own updates land. Every request transfer queues its predicted
	// response; every response transfer is checked against the oldest one.
	always @(posedge clk) begin
		fr_pkg::rsp_t want;
		req_fire <= req_valid && req_ready;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_reductions.push_back(reduce_fraction(req));
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_reductions.size() == 0) begin
					report_mismatch($sformatf("response %0d/%0d with no request waiting",
						$signed(rsp.reduced_numerator), $signed(rsp.reduced_denominator)));
				end else begin
					want = expected_reductions.pop_front();
					if (rsp.reduced_numerator !== want.reduced_numerator) begin
						report_mismatch($sformatf("reduced_numerator %0d, expected %0d",
							$signed(rsp.reduced_numerator),
							$signed(want.reduced_numerator)));
					end
					if (rsp.reduced_denominator !== want.reduced_denominator) begin
						report_mismatch($sformatf("reduced_denominator %0d, expected %0d",
							$signed(rsp.reduced_denominator),
							$signed(want.reduced_denominator)));
					end
					if (rsp.was_reduced !== want.was_reduced) begin
						report_mismatch($sformatf("was_reduced %b, expected %b",
							rsp.was_reduced, want.was_reduced));
					end
					if (rsp.zero_denominator !== want.zero_denominator) begin
						report_mismatch($sformatf("zero_denominator %b, expected %b",
							rsp.zero_denominator, want.zero_denominator));
					end
				end
			end
		end
	end

	// Stimulus and phases. Each phase sets how often the two sides idle,
	// fills the queue and lets the driver empty it before the next begins.
	// The first phase runs without idling and opens with the directed cases.
	initial begin
		fr_pkg::req_t item;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
					for (int i = 0; i < NUM_DIRECTED; i++) begin
						item.numerator = directed_num[i];
						item.denominator = directed_den[i];
						pending_fractions.push_back(item);
					end
				end
				1: begin
					sender_idle_pct = 70;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 70;
				end
				default: begin
					sender_idle_pct = 21;
					receiver_stall_pct = 21;
				end
			endcase
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				pending_fractions.push_back(random_fraction());
			end
			while (pending_fractions.size() != 0 || req_valid) begin
				@(posedge clk);
			end
		end
		// Let the remaining responses out without stalls, then give the
		// block time to show any stray response.
		receiver_stall_pct = 0;
		while (expected_reductions.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog: ends a hung run and reports it as failed.
	initial begin
		#15000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire

// ----- fraction_reducer.f -----
hdl/fr_pkg.sv
hdl/fr_gcd.sv
hdl/fr_div.sv
hdl/fraction_reducer.sv
test/tb_top.sv
